// File: hw/rtl/ascending_value_sorter_macros.svh
// Assertion macros for the ascending value sorter checker.
// Depends on nothing; included by the checker file only.
`ifndef ASCENDING_VALUE_SORTER_MACROS_SVH
`define ASCENDING_VALUE_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorter port check failed");

// The consequent must hold in the cycle after the antecedent.
`define AVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorter port check failed");

`endif

// File: hw/rtl/avs_pkg.sv
// Shared types and constants for the ascending value sorter.
// Depends on nothing; imported by every sorter module.
`default_nettype none

package avs_pkg;

  localparam int MaxItems   = 64;
  localparam int ValueBits  = 32;
  localparam int DataBits   = 32;
  // Values are kept at no more than the port width.
  localparam int StoreBits  = (ValueBits < DataBits) ? ValueBits : DataBits;
  localparam int CountBits  = $clog2(MaxItems + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } avs_state_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                 load;
    logic                 shift;
    logic [StoreBits-1:0] value;
  } avs_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/avs_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on avs_pkg.
`default_nettype none

module avs_cell import avs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire avs_cmd_t             cmd_i,
  input  wire logic                 left_gt_i,
  input  wire logic [StoreBits-1:0] left_value_i,
  input  wire logic                 left_valid_i,
  input  wire logic [StoreBits-1:0] right_value_i,
  input  wire logic                 right_valid_i,
  output logic [StoreBits-1:0]      value_o,
  output logic                      valid_o,
  output logic                      gt_o
);

  logic [StoreBits-1:0] value_q, value_d;
  logic                 valid_q, valid_d;

  // An empty cell counts as larger than any incoming value.
  assign gt_o = !valid_q || ($signed(cmd_i.value) < $signed(value_q));

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.shift) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (cmd_i.load && gt_o) begin
      if (left_gt_i) begin
        value_d = left_value_i;
        valid_d = left_valid_i;
      end else begin
        value_d = cmd_i.value;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/avs_ctrl.sv
// Controller of the sorter: fill count, drop mark, drain sequencing and result flags.
// Depends on avs_pkg.
`default_nettype none

module avs_ctrl import avs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 set_end_i,
  input  wire logic [StoreBits-1:0] value_i,
  output avs_cmd_t                  cmd_o,
  output logic                      busy_o,
  output logic                      strobe_o,
  output logic                      final_o,
  output logic                      overflow_o
);

  avs_state_e           state_q, state_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 drop_q, drop_d;
  logic                 strobe_q, strobe_d;
  logic                 final_q, final_d;
  logic                 ovf_q, ovf_d;
  logic                 accept;
  logic                 room;

  assign accept = start_i && (state_q == ST_LOAD);
  assign room   = (count_q < CountBits'(MaxItems));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    strobe_d    = 1'b0;
    final_d     = 1'b0;
    ovf_d       = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.shift = 1'b0;
    cmd_o.value = value_i;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            cmd_o.load = 1'b1;
            count_d    = count_q + CountBits'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (set_end_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd_o.shift = 1'b1;
        strobe_d    = 1'b1;
        ovf_d       = drop_q;
        final_d     = (count_q == CountBits'(1));
        count_d     = count_q - CountBits'(1);
        if (count_q == CountBits'(1)) begin
          state_d = ST_LOAD;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      drop_q   <= 1'b0;
      strobe_q <= 1'b0;
      final_q  <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      drop_q   <= drop_d;
      strobe_q <= strobe_d;
      final_q  <= final_d;
      ovf_q    <= ovf_d;
    end
  end

  assign busy_o     = (state_q == ST_DRAIN);
  assign strobe_o   = strobe_q;
  assign final_o    = final_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

// File: hw/rtl/ascending_value_sorter.sv
// Top level of the ascending value sorter: a chain of sorting cells plus its controller.
// Depends on avs_pkg, avs_cell and avs_ctrl.
`default_nettype none

// The sorter collects a set of signed Q16.16 words and returns them smallest
// first. A word is accepted on a rising edge where start_i is high and busy_o
// is low. While a set is being loaded, words may follow back to back: each
// is inserted straight into its sorted place in a chain of 64 cells, each of
// which compares the new word against its own and shifts the larger one to
// its right-hand neighbor. The word with set_end_i high closes the set. From
// the next cycle on busy_o is high and the chain shifts toward its head once
// a cycle, so a set of n stored words gives its n results back to back, each
// shown for exactly one cycle with valid_o high. The receiver cannot stall
// these results and must take one every cycle. final_flag_o marks the
// largest word of the set, and overflow_flag_o is high on every result of a
// set that received more than 64 words; the extra words are dropped. The
// first word of the next set may be given in the cycle in which the final
// result is shown.
module ascending_value_sorter import avs_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic signed [DataBits-1:0] sample_value_i,
  input  wire logic                       set_end_i,
  output logic                            valid_o,
  output logic signed [DataBits-1:0]      sorted_value_o,
  output logic                            final_flag_o,
  output logic                            overflow_flag_o
);

  avs_cmd_t             cmd;
  logic [StoreBits-1:0] cell_value [MaxItems];
  logic                 cell_valid [MaxItems];
  logic                 cell_gt    [MaxItems];
  logic [StoreBits-1:0] out_value_q;

  // Only the low bits of each word are kept when the store is narrower.
  avs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .set_end_i  (set_end_i),
    .value_i    (sample_value_i[StoreBits-1:0]),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .strobe_o   (valid_o),
    .final_o    (final_flag_o),
    .overflow_o (overflow_flag_o)
  );

  // The chain is kept in ascending order with the empty cells at its tail.
  // On a load, the cells whose word is larger than the new one move right by
  // one place and the first of them takes the new word. On a drain, every
  // cell takes the word of its right-hand neighbor.
  for (genvar k = 0; k < MaxItems; k++) begin : g_cell
    logic                 left_gt;
    logic [StoreBits-1:0] left_value;
    logic                 left_valid;
    logic [StoreBits-1:0] right_value;
    logic                 right_valid;

    if (k == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_value = '0;
      assign left_valid = 1'b0;
    end else begin : g_body
      assign left_gt    = cell_gt[k-1];
      assign left_value = cell_value[k-1];
      assign left_valid = cell_valid[k-1];
    end

    if (k == MaxItems - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[k+1];
      assign right_valid = cell_valid[k+1];
    end

    avs_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_gt_i     (left_gt),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .value_o       (cell_value[k]),
      .valid_o       (cell_valid[k]),
      .gt_o          (cell_gt[k])
    );
  end

  // The head of the chain is the smallest word left; it is registered as
  // the chain shifts, so it appears together with the strobe.
  always_ff @(posedge clk_i) begin
    if (cmd.shift) begin
      out_value_q <= cell_value[0];
    end
  end

  // Sign extension back to the port width.
  assign sorted_value_o = DataBits'($signed(out_value_q));

endmodule

`default_nettype wire

// File: hw/rtl/avs_checker.sv
// Port-level checker for the ascending value sorter, bound to its top level.
// Depends on ascending_value_sorter_macros.svh.
`default_nettype none

`include "ascending_value_sorter_macros.svh"

module avs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic set_end_i,
  input wire logic valid_o,
  input wire logic final_flag_o,
  input wire logic overflow_flag_o
);

  // Flags only mean something with a result word.
  `AVS_ASSERT_NOW(a_final_has_strobe, clk_i, rst_ni, final_flag_o, valid_o)

  // The results of a set come on back-to-back cycles until the final one.
  `AVS_ASSERT_NEXT(a_drain_contiguous, clk_i, rst_ni, valid_o && !final_flag_o, valid_o)

  // The overflow flag is the same on every result of a set.
  `AVS_ASSERT_NEXT(a_overflow_steady, clk_i, rst_ni, valid_o && !final_flag_o,
                   overflow_flag_o == $past(overflow_flag_o))

  // A word that does not close a set gives no result.
  `AVS_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni,
                   start_i && !busy_o && !set_end_i, !valid_o)

  // The block stays busy while results other than the final one come out.
  `AVS_ASSERT_NOW(a_busy_in_drain, clk_i, rst_ni, valid_o && !final_flag_o, busy_o)

endmodule

bind ascending_value_sorter avs_checker u_avs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .set_end_i       (set_end_i),
  .valid_o         (valid_o),
  .final_flag_o    (final_flag_o),
  .overflow_flag_o (overflow_flag_o)
);

`default_nettype wire

// File: tb/sv/ascending_value_sorter_tb.sv
// Self-checking testbench for the ascending value sorter: streams sets of signed Q16.16 words.
// Every result is checked against an in-order prediction of each closed set.
// Depends on avs_pkg and ascending_value_sorter.
`timescale 1ns / 1ps

module ascending_value_sorter_tb;
  import avs_pkg::*;

  localparam int ItemTarget = 430;
  localparam int StallLimit = 2000;
  localparam int TailCycles = 3 * MaxItems;

  typedef logic signed [DataBits-1:0] word_t;

  typedef struct {
    word_t value;
    logic  final_flag;
    logic  overflow_flag;
  } sorted_word_t;

  // Keeps the open set in ascending order as words are accepted, just as the
  // cell chain does, and turns it into a list of expected results on close.
  class sorted_set_tracker;
    word_t        open_set[$];
    logic         dropped;
    sorted_word_t expected_words[$];
    int           errors;

    function new();
      dropped = 1'b0;
      errors  = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_word(word_t value, logic set_end);
      word_t        narrowed;
      word_t        swap;
      sorted_word_t item;
      int           k;
      // Only the low StoreBits bits of a word are kept, sign extended.
      narrowed = (value <<< (DataBits - StoreBits)) >>> (DataBits - StoreBits);
      if (open_set.size() < MaxItems) begin
        open_set.push_back(narrowed);
        k = open_set.size() - 1;
        while (k > 0 && open_set[k-1] > open_set[k]) begin
          swap          = open_set[k-1];
          open_set[k-1] = open_set[k];
          open_set[k]   = swap;
          k--;
        end
      end else begin
        // The store is full, so the word is lost, even when it closes the set.
        dropped = 1'b1;
      end
      if (set_end) begin
        for (k = 0; k < open_set.size(); k++) begin
          item.value         = open_set[k];
          item.final_flag    = (k == open_set.size() - 1);
          item.overflow_flag = dropped;
          expected_words.push_back(item);
        end
        open_set.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(word_t value, logic final_flag, logic overflow_flag);
      sorted_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: sorted_value %0d", value);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (value !== want.value) begin
        $error("sorted_value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (final_flag !== want.final_flag) begin
        $error("final_flag: expected %0b, actual %0b", want.final_flag, final_flag);
        errors++;
      end
      if (overflow_flag !== want.overflow_flag) begin
        $error("overflow_flag: expected %0b, actual %0b", want.overflow_flag, overflow_flag);
        errors++;
      end
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  word_t sample_value_i;
  logic  set_end_i;
  logic  valid_o;
  word_t sorted_value_o;
  logic  final_flag_o;
  logic  overflow_flag_o;

  sorted_set_tracker tracker;
  int                items_sent;
  int                stall_cycles = 0;
  bit                quiet_stretch;

  ascending_value_sorter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_value_i (sample_value_i),
    .set_end_i      (set_end_i),
    .valid_o        (valid_o),
    .sorted_value_o (sorted_value_o),
    .final_flag_o   (final_flag_o),
    .overflow_flag_o(overflow_flag_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results cannot be held off, so every strobed cycle is checked at the
  // edge that ends it. The watchdog resets whenever either side moves a word.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      tracker.check_result(sorted_value_o, final_flag_o, overflow_flag_o);
    end
    if (!rst_ni || valid_o || (start_i && !busy_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("ascending_value_sorter regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Holds start low, with junk on the data ports that the block must ignore,
  // for the number of cycles given in its argument.
  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i        <= 1'b0;
      sample_value_i <= $urandom;
      set_end_i      <= $urandom_range(0, 1);
    end
  endtask

  // Presents one word and keeps it up until the block takes it. While the
  // block drains a set the word simply waits with start high.
  task automatic send_word(input word_t value, input logic set_end);
    if (!quiet_stretch && $urandom_range(0, 99) < 4) begin
      idle_for($urandom_range(1, 4));
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    sample_value_i <= value;
    set_end_i      <= set_end;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    tracker.note_word(value, set_end);
    items_sent++;
  endtask

  // Value styles: full range, a narrow band that forces duplicates, the
  // extremes with zero and -1, and Q16.16 words with integer parts -3 to 3 and tiny fractions.
  function automatic word_t pick_value(input int style);
    case (style)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(DataBits-1){1'b0}}};
          1: return {1'b0, {(DataBits-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return word_t'(($signed($urandom_range(0, 6)) - 3) * 65536
                              + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_set(input int size, input int style);
    for (int k = 0; k < size; k++) begin
      send_word(pick_value(style), k == size - 1);
    end
  endtask

  initial begin
    int set_index;
    int size;

    tracker        = new();
    items_sent     = 0;
    quiet_stretch  = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    sample_value_i = '0;
    set_end_i      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-word sets at both extremes of the signed range.
    send_word({1'b1, {(DataBits-1){1'b0}}}, 1'b1);
    send_word({1'b0, {(DataBits-1){1'b1}}}, 1'b1);
    // A mixed set with both extremes, zero, signs around zero and a duplicate.
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word({1'b0, {(DataBits-1){1'b1}}}, 1'b0);
    send_word({1'b1, {(DataBits-1){1'b0}}}, 1'b0);
    send_word(5, 1'b0);
    send_word(5, 1'b0);
    send_word(-5, 1'b1);
    // Alternating bit patterns, then a set of identical words.
    send_word(word_t'(32'hAAAA_AAAA), 1'b0);
    send_word(word_t'(32'h5555_5555), 1'b1);
    send_word(7 * 65536, 1'b0);
    send_word(7 * 65536, 1'b0);
    send_word(7 * 65536, 1'b1);

    // Hold back until the block has drained everything it owes.
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);

    // The first random sets cover an exactly full store, a closing word that
    // is dropped, and a set that loses several words. Later sets are mostly
    // small, with an occasional large one.
    set_index = 0;
    while (items_sent < ItemTarget) begin
      case (set_index)
        0: size = MaxItems;
        1: size = MaxItems + 1;
        2: size = MaxItems + 7;
        default: begin
          case ($urandom_range(0, 9))
            0: size = $urandom_range(9, MaxItems - 1);
            1: size = $urandom_range(MaxItems - 1, MaxItems + 8);
            default: size = $urandom_range(1, 8);
          endcase
        end
      endcase
      quiet_stretch = (set_index >= 6 && set_index < 14);
      send_set(size, $urandom_range(0, 3));
      set_index++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ascending_value_sorter regression: pass");
    end else begin
      $display("ascending_value_sorter regression: fail");
    end
    $finish;
  end

endmodule
